// File: rtl/utrb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utrb_pkg;

  // ring sizes, as address widths
  localparam int TX_ADDR_BITS = 12;
  localparam int RX_ADDR_BITS = 12;

  // width of the reported fill counts
  localparam int COUNT_W = 12;

  // item kinds
  localparam logic [2:0] KIND_HOST_WRITE = 3'd0;
  localparam logic [2:0] KIND_HOST_READ  = 3'd1;
  localparam logic [2:0] KIND_TX_READY   = 3'd2;
  localparam logic [2:0] KIND_RX_BYTE    = 3'd3;
  localparam logic [2:0] KIND_CLEAR      = 3'd4;

  // input word
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
  } item_t;

  // result word
  typedef struct packed {
    logic               accepted;
    logic [7:0]         read_data;
    logic               send_valid;
    logic [7:0]         send_byte;
    logic               tx_irq_enable;
    logic [COUNT_W-1:0] rx_count;
    logic [COUNT_W-1:0] tx_count;
  } result_t;

  // controller states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

`default_nettype wire

// File: rtl/uart_tx_rx_ring_buffers_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   valid         ready         word
// input     item_valid    item_ready    item   (utrb_pkg::item_t)
// result    result_valid  result_ready  result (utrb_pkg::result_t)
//
// each word is handled as capture with the ring read, then execute
// one word at a time; no new word is taken until the last one executes
// a waiting result sits in the output register while the next word is taken
// the execute step holds until the output register has room
// synchronous reset empties both rings and clears the interrupt enable

module uart_tx_rx_ring_buffers_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire utrb_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output utrb_pkg::result_t      result
);

  utrb_pkg::cmd_t cmd;

  // sequencing
  utrb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cmd          (cmd)
  );

  // rings, pointers and result register
  utrb_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .result (result)
  );

endmodule

`default_nettype wire

// File: rtl/utrb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module utrb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  output logic               result_valid,
  input  wire logic          result_ready,
  output utrb_pkg::cmd_t     cmd
);

  utrb_pkg::state_t state;
  utrb_pkg::state_t state_next;
  logic             result_valid_next;
  logic             out_free;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= utrb_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    out_free          = !result_valid || result_ready;
    state_next        = state;
    item_ready        = 1'b0;
    cmd               = '0;
    result_valid_next = result_valid && !result_ready;
    case (state)
      utrb_pkg::ST_IDLE: begin
        item_ready  = 1'b1;
        cmd.capture = item_valid;
        if (item_valid) begin
          state_next = utrb_pkg::ST_EXEC;
        end
      end
      utrb_pkg::ST_EXEC: begin
        // wait for room in the output register
        if (out_free) begin
          cmd.commit        = 1'b1;
          result_valid_next = 1'b1;
          state_next        = utrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = utrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/utrb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module utrb_datapath (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire utrb_pkg::cmd_t  cmd,
  input  wire utrb_pkg::item_t item,
  output utrb_pkg::result_t    result
);

  localparam int TXA = utrb_pkg::TX_ADDR_BITS;
  localparam int RXA = utrb_pkg::RX_ADDR_BITS;
  localparam int CW  = utrb_pkg::COUNT_W;

  // byte stores
  logic [7:0] tx_mem [2**TXA];
  logic [7:0] rx_mem [2**RXA];

  logic [TXA-1:0] tx_write_ptr, tx_write_ptr_next;
  logic [TXA-1:0] tx_read_ptr, tx_read_ptr_next;
  logic [RXA-1:0] rx_write_ptr, rx_write_ptr_next;
  logic [RXA-1:0] rx_read_ptr, rx_read_ptr_next;
  logic           send_irq_on, send_irq_on_next;

  utrb_pkg::item_t   cur;
  utrb_pkg::result_t res_next;
  logic [7:0]        tx_rd_data;
  logic [7:0]        rx_rd_data;

  logic           tx_full, tx_empty, rx_full, rx_empty;
  logic           tx_we, rx_we;
  logic [TXA-1:0] tx_diff;
  logic [RXA-1:0] rx_diff;
  logic [CW+TXA-1:0] tx_diff_ext;
  logic [CW+RXA-1:0] rx_diff_ext;

  // latch the word and read both rings at their read pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur        <= item;
      tx_rd_data <= tx_mem[tx_read_ptr];
      rx_rd_data <= rx_mem[rx_read_ptr];
    end
  end

  // ring writes
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_write_ptr] <= cur.data_byte;
    end
    if (rx_we) begin
      rx_mem[rx_write_ptr] <= cur.data_byte;
    end
  end

  // pointers and interrupt enable
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_write_ptr <= '0;
      tx_read_ptr  <= '0;
      rx_write_ptr <= '0;
      rx_read_ptr  <= '0;
      send_irq_on  <= 1'b0;
    end else if (cmd.commit) begin
      tx_write_ptr <= tx_write_ptr_next;
      tx_read_ptr  <= tx_read_ptr_next;
      rx_write_ptr <= rx_write_ptr_next;
      rx_read_ptr  <= rx_read_ptr_next;
      send_irq_on  <= send_irq_on_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  // ring operation for the held word
  always_comb begin
    tx_full  = (tx_write_ptr + 1'b1) == tx_read_ptr;
    tx_empty = tx_write_ptr == tx_read_ptr;
    rx_full  = (rx_write_ptr + 1'b1) == rx_read_ptr;
    rx_empty = rx_write_ptr == rx_read_ptr;

    tx_write_ptr_next = tx_write_ptr;
    tx_read_ptr_next  = tx_read_ptr;
    rx_write_ptr_next = rx_write_ptr;
    rx_read_ptr_next  = rx_read_ptr;
    send_irq_on_next  = send_irq_on;
    tx_we             = 1'b0;
    rx_we             = 1'b0;
    res_next          = '0;

    case (cur.kind)
      utrb_pkg::KIND_HOST_WRITE: begin
        if (!tx_full) begin
          tx_we             = cmd.commit;
          tx_write_ptr_next = tx_write_ptr + 1'b1;
          send_irq_on_next  = 1'b1;
          res_next.accepted = 1'b1;
        end
      end
      utrb_pkg::KIND_HOST_READ: begin
        if (!rx_empty) begin
          res_next.read_data = rx_rd_data;
          rx_read_ptr_next   = rx_read_ptr + 1'b1;
          res_next.accepted  = 1'b1;
        end
      end
      utrb_pkg::KIND_TX_READY: begin
        if (tx_empty) begin
          send_irq_on_next = 1'b0;
        end else begin
          res_next.send_byte  = tx_rd_data;
          res_next.send_valid = 1'b1;
          tx_read_ptr_next    = tx_read_ptr + 1'b1;
        end
      end
      utrb_pkg::KIND_RX_BYTE: begin
        if (!rx_full) begin
          rx_we             = cmd.commit;
          rx_write_ptr_next = rx_write_ptr + 1'b1;
          res_next.accepted = 1'b1;
        end
      end
      utrb_pkg::KIND_CLEAR: begin
        tx_write_ptr_next = '0;
        tx_read_ptr_next  = '0;
        rx_write_ptr_next = '0;
        rx_read_ptr_next  = '0;
      end
      default: begin
      end
    endcase

    // fill counts after the operation, fitted to the count width
    tx_diff     = tx_write_ptr_next - tx_read_ptr_next;
    rx_diff     = rx_write_ptr_next - rx_read_ptr_next;
    tx_diff_ext = {{CW{1'b0}}, tx_diff};
    rx_diff_ext = {{CW{1'b0}}, rx_diff};

    res_next.tx_irq_enable = send_irq_on_next;
    res_next.tx_count      = tx_diff_ext[CW-1:0];
    res_next.rx_count      = rx_diff_ext[CW-1:0];
  end

endmodule

`default_nettype wire

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int TX_SLOTS = 1 << utrb_pkg::TX_ADDR_BITS;
  localparam int RX_SLOTS = 1 << utrb_pkg::RX_ADDR_BITS;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 20;
  localparam int BURST_LEN = 48;
  localparam int RANDOM_LEN = 120;

  // kinds the block treats as no operation
  localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;

  logic              clk = 1'b0;
  logic              rst;
  logic              item_valid;
  logic              item_ready;
  utrb_pkg::item_t   item;
  logic              result_valid;
  logic              result_ready;
  utrb_pkg::result_t result;

  // copy of the rings, kept in step with accepted words
  logic [7:0]                        tx_bytes [0:TX_SLOTS-1];
  logic [7:0]                        rx_bytes [0:RX_SLOTS-1];
  logic [utrb_pkg::TX_ADDR_BITS-1:0] tx_wr_idx, tx_rd_idx;
  logic [utrb_pkg::RX_ADDR_BITS-1:0] rx_wr_idx, rx_rd_idx;
  logic                              tx_irq_on;

  utrb_pkg::result_t ring_results_due [$];
  utrb_pkg::result_t due_word;
  int                error_count = 0;
  int                quiet_cycles = 0;
  bit                steady_run = 1'b0;

  uart_tx_rx_ring_buffers_core DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // expected result of one accepted word, updating the ring copy
  function automatic utrb_pkg::result_t advance_rings(input utrb_pkg::item_t w);
    utrb_pkg::result_t                 r;
    logic [utrb_pkg::TX_ADDR_BITS-1:0] tx_next, tx_fill;
    logic [utrb_pkg::RX_ADDR_BITS-1:0] rx_next, rx_fill;
    r = '0;
    tx_next = tx_wr_idx + 1'b1;
    rx_next = rx_wr_idx + 1'b1;
    case (w.kind)
      utrb_pkg::KIND_HOST_WRITE: begin
        if (tx_next != tx_rd_idx) begin
          tx_bytes[tx_wr_idx] = w.data_byte;
          tx_wr_idx = tx_next;
          tx_irq_on = 1'b1;
          r.accepted = 1'b1;
        end
      end
      utrb_pkg::KIND_HOST_READ: begin
        if (rx_wr_idx != rx_rd_idx) begin
          r.read_data = rx_bytes[rx_rd_idx];
          rx_rd_idx = rx_rd_idx + 1'b1;
          r.accepted = 1'b1;
        end
      end
      utrb_pkg::KIND_TX_READY: begin
        if (tx_wr_idx == tx_rd_idx) begin
          tx_irq_on = 1'b0;
        end else begin
          r.send_byte = tx_bytes[tx_rd_idx];
          r.send_valid = 1'b1;
          tx_rd_idx = tx_rd_idx + 1'b1;
        end
      end
      utrb_pkg::KIND_RX_BYTE: begin
        if (rx_next != rx_rd_idx) begin
          rx_bytes[rx_wr_idx] = w.data_byte;
          rx_wr_idx = rx_next;
          r.accepted = 1'b1;
        end
      end
      utrb_pkg::KIND_CLEAR: begin
        tx_wr_idx = '0;
        tx_rd_idx = '0;
        rx_wr_idx = '0;
        rx_rd_idx = '0;
      end
      default: begin
      end
    endcase
    tx_fill = tx_wr_idx - tx_rd_idx;
    rx_fill = rx_wr_idx - rx_rd_idx;
    r.tx_irq_enable = tx_irq_on;
    r.rx_count = utrb_pkg::COUNT_W'(rx_fill);
    r.tx_count = utrb_pkg::COUNT_W'(tx_fill);
    return r;
  endfunction

  function automatic utrb_pkg::item_t word_of(input logic [2:0] k, input logic [7:0] b);
    utrb_pkg::item_t w;
    w.kind = k;
    w.data_byte = b;
    return w;
  endfunction

  // offer one word, called and returning at a falling edge
  task automatic send_word(input utrb_pkg::item_t w);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 25) begin
        item_valid <= 1'b0;
        @(negedge clk);
      end
    end
    item_valid <= 1'b1;
    item <= w;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    ring_results_due.push_back(advance_rings(w));
    @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (ring_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // result side stalls at random, but never during a steady run
  always @(negedge clk) begin
    result_ready <= steady_run || ($urandom_range(0, 99) >= 25);
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (ring_results_due.size() == 0) begin
        $display("%0t ns: result with nothing expected, got %h", $time, result);
        error_count++;
      end else begin
        due_word = ring_results_due.pop_front();
        check_field("accepted", due_word.accepted, result.accepted);
        check_field("read_data", due_word.read_data, result.read_data);
        check_field("send_valid", due_word.send_valid, result.send_valid);
        check_field("send_byte", due_word.send_byte, result.send_byte);
        check_field("tx_irq_enable", due_word.tx_irq_enable, result.tx_irq_enable);
        check_field("rx_count", due_word.rx_count, result.rx_count);
        check_field("tx_count", due_word.tx_count, result.tx_count);
      end
    end
  end

  // cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

  // empty rings: a read, transmit ready with enable off, spare kinds, clear
  task automatic test_empty_rings();
    send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'h00));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'hFF));
    for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++) begin
      send_word(word_of(3'(k), 8'hA5));
    end
    send_word(word_of(utrb_pkg::KIND_CLEAR, 8'h5A));
  endtask

  // each operation with data, byte extremes, clear with data held
  task automatic test_basic_ops();
    send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'h00));
    send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'hFF));
    send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'hFF));
    send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'h00));
    send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'h3C));
    send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'hC3));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
    send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'h81));
    send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'h7E));
    send_word(word_of(utrb_pkg::KIND_CLEAR, 8'hFF));
    send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'h00));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
    send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
  endtask

  // burst into both rings, drain past empty, then refill, drain again, refill and clear
  task automatic test_ring_bursts();
    for (int i = 0; i < BURST_LEN; i++) begin
      send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'($urandom_range(0, 255))));
    end
    for (int i = 0; i < BURST_LEN; i++) begin
      send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'($urandom_range(0, 255))));
    end
    for (int i = 0; i < BURST_LEN + 2; i++) begin
      send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'($urandom_range(0, 255))));
      send_word(word_of(utrb_pkg::KIND_TX_READY, 8'($urandom_range(0, 255))));
    end
    for (int i = 0; i < 3; i++) begin
      send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'($urandom_range(0, 255))));
      send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'($urandom_range(0, 255))));
    end
    for (int i = 0; i < 3; i++) begin
      send_word(word_of(utrb_pkg::KIND_HOST_READ, 8'h00));
      send_word(word_of(utrb_pkg::KIND_TX_READY, 8'h00));
    end
    send_word(word_of(utrb_pkg::KIND_HOST_WRITE, 8'h55));
    send_word(word_of(utrb_pkg::KIND_RX_BYTE, 8'hAA));
    send_word(word_of(utrb_pkg::KIND_CLEAR, 8'h00));
  endtask

  // random traffic, balanced so the rings keep passing through empty, or tilted toward filling when grow is set
  function automatic utrb_pkg::item_t random_word(input bit grow);
    int unsigned pick;
    logic [7:0]  b;
    pick = $urandom_range(0, 99);
    b = 8'($urandom_range(0, 255));
    if (pick < 2) return word_of(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), b);
    if (pick < 4) return word_of(utrb_pkg::KIND_CLEAR, b);
    if (grow) begin
      if (pick < 39) return word_of(utrb_pkg::KIND_HOST_WRITE, b);
      if (pick < 52) return word_of(utrb_pkg::KIND_TX_READY, b);
      if (pick < 87) return word_of(utrb_pkg::KIND_RX_BYTE, b);
      return word_of(utrb_pkg::KIND_HOST_READ, b);
    end
    if (pick < 28) return word_of(utrb_pkg::KIND_HOST_WRITE, b);
    if (pick < 52) return word_of(utrb_pkg::KIND_TX_READY, b);
    if (pick < 76) return word_of(utrb_pkg::KIND_RX_BYTE, b);
    return word_of(utrb_pkg::KIND_HOST_READ, b);
  endfunction

  task automatic test_random_traffic();
    repeat (RANDOM_LEN) send_word(random_word(1'b0));
    wait_drained();
    steady_run = 1'b1;
    repeat (RANDOM_LEN) send_word(random_word(1'b1));
    steady_run = 1'b0;
    repeat (RANDOM_LEN) send_word(random_word(1'b0));
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    result_ready = 1'b0;
    tx_wr_idx = '0;
    tx_rd_idx = '0;
    rx_wr_idx = '0;
    rx_rd_idx = '0;
    tx_irq_on = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_rings();
    test_basic_ops();
    test_ring_bursts();
    test_random_traffic();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/utrb_pkg.sv
rtl/utrb_ctrl.sv
rtl/utrb_datapath.sv
rtl/uart_tx_rx_ring_buffers_core.sv
sim/testbench.sv
